// ===== hdl/rc_servo_frame_decoder_core_macros.svh =====
// Assertion macros for the RC servo frame decoder.
`ifndef RC_SERVO_FRAME_DECODER_CORE_MACROS_SVH
`define RC_SERVO_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define RCSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define RCSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rcsfd_pkg.sv =====
// Types and constants shared by the RC servo frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcsfd_pkg;

  localparam int CHANNELS_DEF = 14;

  localparam logic [7:0] FAILSAFE_LIMIT_RST = 8'd50;

  localparam logic [7:0] HDR0 = 8'h20;
  localparam logic [7:0] HDR1 = 8'h40;

  localparam logic [4:0] POS_HDR0    = 5'd0;
  localparam logic [4:0] POS_HDR1    = 5'd1;
  localparam logic [4:0] POS_CH0_HI  = 5'd3;
  localparam logic [4:0] POS_CSUM_LO = 5'd30;
  localparam logic [4:0] POS_LAST    = 5'd31;

  localparam logic [15:0] CSUM_BASE = 16'hFFFF;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    STAT_VALID    = 2'd0,
    STAT_BAD_HDR  = 2'd1,
    STAT_BAD_SUM  = 2'd2,
    STAT_FAILSAFE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_STATUS
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/rcsfd_chan_ram.sv =====
// Channel store: single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rcsfd_chan_ram #(
  parameter int DEPTH = rcsfd_pkg::CHANNELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc_servo_frame_decoder_core.sv =====
// A byte or tick is taken while the sequencer is idle; a bad frame's status goes through
// the S_STATUS state, then the output register. A good frame or failsafe gives CHANNELS
// results, each by a RAM read in S_READ, then an output load in S_EMIT that waits on out_free.
// Input is held off during a burst. Reset: frame state and failsafe count cleared, limit 50;
// the channel RAM is not cleared, as each entry is written before any frame end reads it.
`timescale 1ns / 1ps
`default_nettype none

`include "rc_servo_frame_decoder_core_macros.svh"

module rc_servo_frame_decoder_core #(
  parameter int CHANNELS = rcsfd_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,     // failsafe_limit
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] rx_byte
  input  wire logic        in_tuser,     // [0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,    // [3:0] channel_index, [19:4] channel_value
  output logic      [1:0]  out_tuser,    // [1:0] status
  output logic             out_tlast
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);
  localparam logic [3:0] CH_COUNT = 4'(CHANNELS);

  rcsfd_pkg::state_t state_r, state_nxt;

  logic [7:0]       limit_r;
  logic [4:0]       pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic             hdr_r, hdr_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             zero_r, zero_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_idx_r, out_idx_nxt;
  logic [15:0]      out_val_r, out_val_nxt;
  logic [1:0]       out_stat_r, out_stat_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc, byte_acc, tick_acc;
  logic             fire, frame_end, frame_bad;
  logic [7:0]       cnt_inc;
  logic [4:0]       pos_m3;
  logic [3:0]       ch;
  logic             wr_en;
  logic             rd_en;
  logic [15:0]      rd_data;
  logic             out_free, load;
  logic [15:0]      expect_sum, got_sum;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == rcsfd_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign byte_acc   = in_acc && (in_tuser == rcsfd_pkg::CMD_BYTE);
  assign tick_acc   = in_acc && (in_tuser == rcsfd_pkg::CMD_TICK);
  assign out_free   = !out_valid_r || out_tready;

  assign pos_m3     = pos_r - rcsfd_pkg::POS_CH0_HI;
  assign ch         = pos_m3[4:1];
  assign expect_sum = rcsfd_pkg::CSUM_BASE - sum_r;
  assign got_sum    = {in_tdata, low_r};

  // Frame and failsafe bookkeeping
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    hdr_nxt   = hdr_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    stat_nxt  = stat_r;
    cnt_inc   = cnt_r + 8'd1;
    fire      = 1'b0;
    frame_end = 1'b0;
    frame_bad = 1'b0;
    wr_en     = 1'b0;
    if (tick_acc) begin
      if (limit_r > cnt_inc) begin
        cnt_nxt = cnt_inc;
      end else begin
        cnt_nxt  = 8'd0;
        fire     = 1'b1;
        zero_nxt = 1'b1;
      end
    end
    if (byte_acc) begin
      if (pos_r < rcsfd_pkg::POS_CSUM_LO) begin
        sum_nxt = sum_r + {8'd0, in_tdata};
      end
      if (pos_r == rcsfd_pkg::POS_HDR0) begin
        hdr_nxt = (in_tdata == rcsfd_pkg::HDR0);
      end else if (pos_r == rcsfd_pkg::POS_HDR1) begin
        hdr_nxt = hdr_r && (in_tdata == rcsfd_pkg::HDR1);
      end else if (!pos_r[0]) begin
        low_nxt = in_tdata;
      end else if (pos_r < rcsfd_pkg::POS_CSUM_LO) begin
        wr_en = (ch < CH_COUNT);
      end
      if (pos_r == rcsfd_pkg::POS_LAST) begin
        frame_end = 1'b1;
        zero_nxt  = 1'b0;
        if (!hdr_r) begin
          frame_bad = 1'b1;
          stat_nxt  = rcsfd_pkg::STAT_BAD_HDR;
        end else if (expect_sum != got_sum) begin
          frame_bad = 1'b1;
          stat_nxt  = rcsfd_pkg::STAT_BAD_SUM;
        end
        cnt_nxt = 8'd0;
        pos_nxt = 5'd0;
        sum_nxt = 16'd0;
        hdr_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  // Result sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcsfd_pkg::S_IDLE: begin
        if (fire || (frame_end && !frame_bad)) begin
          state_nxt = rcsfd_pkg::S_READ;
        end else if (frame_end) begin
          state_nxt = rcsfd_pkg::S_STATUS;
        end
      end
      rcsfd_pkg::S_READ: begin
        state_nxt = rcsfd_pkg::S_EMIT;
      end
      rcsfd_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = (idx_r == IDX_LAST) ? rcsfd_pkg::S_IDLE : rcsfd_pkg::S_READ;
        end
      end
      rcsfd_pkg::S_STATUS: begin
        if (out_free) begin
          state_nxt = rcsfd_pkg::S_IDLE;
        end
      end
      default: state_nxt = rcsfd_pkg::S_IDLE;
    endcase
  end

  // Result sequencer: outputs
  always_comb begin
    rd_en        = 1'b0;
    load         = 1'b0;
    idx_nxt      = idx_r;
    out_idx_nxt  = out_idx_r;
    out_val_nxt  = out_val_r;
    out_stat_nxt = out_stat_r;
    out_last_nxt = out_last_r;
    case (state_r)
      rcsfd_pkg::S_IDLE: begin
        idx_nxt = '0;
      end
      rcsfd_pkg::S_READ: begin
        rd_en = 1'b1;
      end
      rcsfd_pkg::S_EMIT: begin
        if (out_free) begin
          load         = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          out_idx_nxt  = 4'(idx_r);
          out_val_nxt  = zero_r ? 16'd0 : rd_data;
          out_stat_nxt = zero_r ? rcsfd_pkg::STAT_FAILSAFE : rcsfd_pkg::STAT_VALID;
          out_last_nxt = (idx_r == IDX_LAST);
        end
      end
      rcsfd_pkg::S_STATUS: begin
        if (out_free) begin
          load         = 1'b1;
          out_idx_nxt  = 4'd0;
          out_val_nxt  = 16'd0;
          out_stat_nxt = stat_r;
          out_last_nxt = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcsfd_pkg::S_IDLE;
      limit_r     <= rcsfd_pkg::FAILSAFE_LIMIT_RST;
      pos_r       <= 5'd0;
      sum_r       <= 16'd0;
      hdr_r       <= 1'b1;
      low_r       <= 8'd0;
      cnt_r       <= 8'd0;
      zero_r      <= 1'b0;
      stat_r      <= rcsfd_pkg::STAT_VALID;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      hdr_r       <= hdr_nxt;
      low_r       <= low_nxt;
      cnt_r       <= cnt_nxt;
      zero_r      <= zero_nxt;
      stat_r      <= stat_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  rcsfd_chan_ram #(
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ch[IDX_W-1:0]),
    .wr_data ({in_tdata, low_r}),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_val_r, out_idx_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  `RCSFD_ASSERT_IMP(a_bad_frame_single,
    out_tvalid && (out_tuser == rcsfd_pkg::STAT_BAD_HDR ||
      out_tuser == rcsfd_pkg::STAT_BAD_SUM),
    out_tlast && (out_tdata == 24'd0),
    "bad frame status must be a single zeroed last transaction")
  `RCSFD_ASSERT_NXT(a_frame_end_busy,
    byte_acc && (pos_r == rcsfd_pkg::POS_LAST),
    (state_r != rcsfd_pkg::S_IDLE) && (pos_r == 5'd0) && (cnt_r == 8'd0),
    "frame end must start results and clear frame state")
  `RCSFD_ASSERT_NXT(a_failsafe_burst,
    fire,
    (state_r == rcsfd_pkg::S_READ) && zero_r && (idx_r == '0),
    "failsafe must start a zeroed burst from channel zero")
  `RCSFD_ASSERT_NXT(a_burst_last,
    load && (state_r == rcsfd_pkg::S_EMIT) && (idx_r == IDX_LAST),
    out_tvalid && out_tlast && (state_r == rcsfd_pkg::S_IDLE),
    "final channel must carry tlast and end the burst")

endmodule

`default_nettype wire
